// ===== rtl/core/glr_pkg.sv =====
// Shared types and constants for the gravity levelling rotation core.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps

package glr_pkg;

  // Width of every matrix entry on the result ports.
  localparam int OUT_W = 16;
  // A vector is scaled so that its largest magnitude lies in [2^30, 2^31).
  localparam int NORM_W = 31;
  // Square root of a sum of three 62-bit squares.
  localparam int ROOT_W = 32;
  localparam int SQ_W = 64;
  // Two root bits are resolved in every square root stage.
  localparam int SQRT_STAGES = ROOT_W / 2;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_DEGEN  = 2'd2
  } status_e;

  // Register stages of one normalizer: magnitude, leading one, scale, square,
  // sum, the square root stages, the divide stages and the sign stage.
  function automatic int norm_latency(int frac);
    return 5 + SQRT_STAGES + (frac + 2) / 2 + 1;
  endfunction

  // Register stages from an accepted item to its result strobe.
  function automatic int core_latency(int frac);
    return 2 * norm_latency(frac) + 6;
  endfunction

endpackage

// ===== rtl/core/glr_norm.sv =====
// Pipelined vector normalizer: scale, sum of squares, square root, divide.
// Depends on glr_pkg.
`timescale 1ns / 1ps

module glr_norm #(
  parameter int IW  = 16,
  parameter int F   = 14,
  parameter int SBW = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [IW-1:0] v_i [3],
  input  logic [SBW-1:0]       sb_i,
  output logic                 valid_o,
  output logic                 zero_o,
  output logic signed [F+1:0]  u_o [3],
  output logic [SBW-1:0]       sb_o
);

  localparam int LW = $clog2(IW);
  localparam int EW = IW + glr_pkg::NORM_W - 1;
  localparam int NW = glr_pkg::NORM_W + F + 1;
  localparam int QW = F + 1;
  localparam int DS = (F + 2) / 2;
  localparam int SS = glr_pkg::SQRT_STAGES;

  typedef logic [glr_pkg::NORM_W-1:0] nm_t;
  typedef struct packed {
    nm_t [2:0]      m;
    logic [2:0]     neg;
    logic           zero;
    logic [SBW-1:0] sb;
  } carry_t;

  // Stage A: component magnitudes.
  logic [IW-1:0]  a_mag_q [3];
  logic [2:0]     a_neg_q;
  logic [SBW-1:0] a_sb_q;
  logic           a_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_v_q <= 1'b0;
    else a_v_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      a_mag_q[i] <= v_i[i][IW-1] ? IW'(-v_i[i]) : IW'(v_i[i]);
      a_neg_q[i] <= v_i[i][IW-1];
    end
    a_sb_q <= sb_i;
  end

  // Stage B: position of the leading one of the largest magnitude.
  logic [IW-1:0]  b_or;
  logic [LW-1:0]  b_lead;
  logic [IW-1:0]  b_mag_q [3];
  logic [2:0]     b_neg_q;
  logic [SBW-1:0] b_sb_q;
  logic [LW-1:0]  b_lead_q;
  logic           b_zero_q;
  logic           b_v_q;

  always_comb begin
    b_or = a_mag_q[0] | a_mag_q[1] | a_mag_q[2];
    b_lead = '0;
    for (int b = 0; b < IW; b++) begin
      if (b_or[b]) b_lead = LW'(b);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_v_q <= 1'b0;
    else b_v_q <= a_v_q;
  end

  always_ff @(posedge clk_i) begin
    b_mag_q  <= a_mag_q;
    b_neg_q  <= a_neg_q;
    b_sb_q   <= a_sb_q;
    b_lead_q <= b_lead;
    b_zero_q <= (b_or == '0);
  end

  // Stage C: scale so that the leading one lands on bit 30. Right shifts
  // truncate, left shifts are exact, so one shift of m * 2^30 does both.
  logic [EW-1:0] c_ext [3];
  carry_t        c_d, c_q;
  logic          c_v_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_ext[i] = EW'(b_mag_q[i]) << (glr_pkg::NORM_W - 1);
      c_d.m[i] = glr_pkg::NORM_W'(c_ext[i] >> b_lead_q);
    end
    c_d.neg  = b_neg_q;
    c_d.zero = b_zero_q;
    c_d.sb   = b_sb_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_v_q <= 1'b0;
    else c_v_q <= b_v_q;
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
  end

  // Stage D: squares.
  logic [2*glr_pkg::NORM_W-1:0] d_sq_q [3];
  carry_t                       d_c_q;
  logic                         d_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_v_q <= 1'b0;
    else d_v_q <= c_v_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      d_sq_q[i] <= c_q.m[i] * c_q.m[i];
    end
    d_c_q <= c_q;
  end

  // Stage E: sum of squares.
  logic [glr_pkg::SQ_W-1:0] e_n_q;
  carry_t                   e_c_q;
  logic                     e_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e_v_q <= 1'b0;
    else e_v_q <= d_v_q;
  end

  always_ff @(posedge clk_i) begin
    e_n_q <= glr_pkg::SQ_W'(d_sq_q[0]) + glr_pkg::SQ_W'(d_sq_q[1])
           + glr_pkg::SQ_W'(d_sq_q[2]);
    e_c_q <= d_c_q;
  end

  // Square root, two root bits per stage, most significant first.
  logic [glr_pkg::SQ_W-1:0]   sq_rem_q  [SS];
  logic [glr_pkg::ROOT_W-1:0] sq_root_q [SS];
  carry_t                     sq_c_q    [SS];
  logic                       sq_v_q    [SS];

  for (genvar k = 0; k < SS; k++) begin : g_sqrt
    logic [glr_pkg::SQ_W-1:0]   rem_in, rem_d;
    logic [glr_pkg::ROOT_W-1:0] root_in, root_d;
    carry_t                     c_in;
    logic                       v_in;

    if (k == 0) begin : g_first
      assign rem_in  = e_n_q;
      assign root_in = '0;
      assign c_in    = e_c_q;
      assign v_in    = e_v_q;
    end else begin : g_next
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
      assign c_in    = sq_c_q[k-1];
      assign v_in    = sq_v_q[k-1];
    end

    always_comb begin
      logic [glr_pkg::SQ_W+1:0] trial;
      int bi;
      rem_d  = rem_in;
      root_d = root_in;
      for (int t = 0; t < 2; t++) begin
        bi = glr_pkg::ROOT_W - 1 - 2 * k - t;
        trial = ((glr_pkg::SQ_W + 2)'(root_d) << (bi + 1))
              + ((glr_pkg::SQ_W + 2)'(1) << (2 * bi));
        if ((glr_pkg::SQ_W + 2)'(rem_d) >= trial) begin
          rem_d      = rem_d - glr_pkg::SQ_W'(trial);
          root_d[bi] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sq_v_q[k] <= 1'b0;
      else sq_v_q[k] <= v_in;
    end

    always_ff @(posedge clk_i) begin
      sq_rem_q[k]  <= rem_d;
      sq_root_q[k] <= root_d;
      sq_c_q[k]    <= c_in;
    end
  end

  // Restoring divide of (m * 2^F + s/2) by s, two quotient bits per stage.
  logic [NW-1:0]              dv_rem_q [DS][3];
  logic [QW-1:0]              dv_quo_q [DS][3];
  logic [glr_pkg::ROOT_W-1:0] dv_s_q   [DS];
  carry_t                     dv_c_q   [DS];
  logic                       dv_v_q   [DS];

  for (genvar d = 0; d < DS; d++) begin : g_div
    logic [NW-1:0]              rem_in [3];
    logic [NW-1:0]              rem_d  [3];
    logic [QW-1:0]              quo_in [3];
    logic [QW-1:0]              quo_d  [3];
    logic [glr_pkg::ROOT_W-1:0] s_in;
    carry_t                     c_in;
    logic                       v_in;

    if (d == 0) begin : g_first
      assign s_in = sq_root_q[SS-1];
      assign c_in = sq_c_q[SS-1];
      assign v_in = sq_v_q[SS-1];
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_in[i] = (NW'(sq_c_q[SS-1].m[i]) << F) + NW'(sq_root_q[SS-1] >> 1);
        assign quo_in[i] = '0;
      end
    end else begin : g_next
      assign s_in   = dv_s_q[d-1];
      assign c_in   = dv_c_q[d-1];
      assign v_in   = dv_v_q[d-1];
      assign rem_in = dv_rem_q[d-1];
      assign quo_in = dv_quo_q[d-1];
    end

    always_comb begin
      logic [NW:0] trial;
      int j;
      for (int i = 0; i < 3; i++) begin
        rem_d[i] = rem_in[i];
        quo_d[i] = quo_in[i];
        for (int t = 0; t < 2; t++) begin
          j = F - 2 * d - t;
          if (j >= 0) begin
            trial = (NW + 1)'(s_in) << j;
            if ((NW + 1)'(rem_d[i]) >= trial) begin
              rem_d[i]    = rem_d[i] - NW'(trial);
              quo_d[i][j] = 1'b1;
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v_q[d] <= 1'b0;
      else dv_v_q[d] <= v_in;
    end

    always_ff @(posedge clk_i) begin
      dv_rem_q[d] <= rem_d;
      dv_quo_q[d] <= quo_d;
      dv_s_q[d]   <= s_in;
      dv_c_q[d]   <= c_in;
    end
  end

  // Final stage: clamp to one and restore the sign.
  logic [QW-1:0]      f_quo [3];
  logic signed [F+1:0] f_u  [3];
  logic signed [F+1:0] u_q  [3];
  logic                v_q, zero_q;
  logic [SBW-1:0]      sb_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f_quo[i] = dv_quo_q[DS-1][i];
      if (f_quo[i] > (QW'(1) << F)) f_quo[i] = QW'(1) << F;
      f_u[i] = dv_c_q[DS-1].neg[i] ? -$signed({1'b0, f_quo[i]}) : $signed({1'b0, f_quo[i]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else v_q <= dv_v_q[DS-1];
  end

  always_ff @(posedge clk_i) begin
    u_q    <= f_u;
    zero_q <= dv_c_q[DS-1].zero;
    sb_q   <= dv_c_q[DS-1].sb;
  end

  assign valid_o = v_q;
  assign zero_o  = zero_q;
  assign u_o     = u_q;
  assign sb_o    = sb_q;

endmodule

// ===== rtl/core/gravity_level_rotation_core.sv =====
// Pipeline from start to done_o: normalizer, G1 to G3, normalizer, C1 to C3.
// Throughput: one item every cycle; busy is never raised and the receiver cannot stall.
// Most of its depth lies in the two normalizers, each with a 16-stage square root
// and a divider resolving two quotient bits per stage.
// Reset clears only the valid bits of the pipeline; no result appears until fed.
// Depends on glr_pkg and glr_norm.
`timescale 1ns / 1ps

module gravity_level_rotation_core #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int FRACTION_BITS = 14
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [SAMPLE_WIDTH-1:0]  grav_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  grav_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  grav_z_i,
  output logic                            done_o,
  output logic [1:0]                      status_o,
  output logic signed [glr_pkg::OUT_W-1:0] r00_o,
  output logic signed [glr_pkg::OUT_W-1:0] r01_o,
  output logic signed [glr_pkg::OUT_W-1:0] r02_o,
  output logic signed [glr_pkg::OUT_W-1:0] r10_o,
  output logic signed [glr_pkg::OUT_W-1:0] r11_o,
  output logic signed [glr_pkg::OUT_W-1:0] r12_o,
  output logic signed [glr_pkg::OUT_W-1:0] r20_o,
  output logic signed [glr_pkg::OUT_W-1:0] r21_o,
  output logic signed [glr_pkg::OUT_W-1:0] r22_o
);

  localparam int F   = FRACTION_BITS;
  localparam int ZW  = F + 2;       // a unit component, range +-2^F
  localparam int PW  = 2 * ZW;      // a product of two unit components
  localparam int DW  = PW + 1;      // a difference of two products
  localparam int AZW = ZW + 4;      // room for ten times |z.x|
  localparam int SBW = 1 + 3 * ZW;

  // The pipeline never holds an item back, so start is always taken.
  assign busy = 1'b0;

  // First normalizer: unit gravity direction Z.
  logic signed [SAMPLE_WIDTH-1:0] n1_in [3];
  logic signed [ZW-1:0]           n1_z  [3];
  logic                           n1_v, n1_zero;

  assign n1_in[0] = grav_x_i;
  assign n1_in[1] = grav_y_i;
  assign n1_in[2] = grav_z_i;

  glr_norm #(.IW(SAMPLE_WIDTH), .F(F), .SBW(1)) u_norm_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .v_i     (n1_in),
    .sb_i    (1'b0),
    .valid_o (n1_v),
    .zero_o  (n1_zero),
    .u_o     (n1_z),
    .sb_o    ()
  );

  // G1: pick the reference axis. Unit Y is taken when |z.x| > 0.9, so the
  // projection of the reference onto Z is simply z.y or z.x.
  logic [ZW-1:0]        g1_az;
  logic                 g1_use_y;
  logic signed [ZW-1:0] g1_z_q [3];
  logic signed [ZW-1:0] g1_proj_q;
  logic                 g1_use_y_q, g1_zero_q, g1_v_q;

  always_comb begin
    g1_az    = n1_z[0][ZW-1] ? ZW'(-n1_z[0]) : ZW'(n1_z[0]);
    g1_use_y = (AZW'(g1_az) * AZW'(10)) > (AZW'(9) << F);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) g1_v_q <= 1'b0;
    else g1_v_q <= n1_v;
  end

  always_ff @(posedge clk_i) begin
    g1_z_q     <= n1_z;
    g1_proj_q  <= g1_use_y ? n1_z[1] : n1_z[0];
    g1_use_y_q <= g1_use_y;
    g1_zero_q  <= n1_zero;
  end

  // G2: projection times each Z component.
  logic signed [PW-1:0] g2_prod_q [3];
  logic signed [ZW-1:0] g2_z_q [3];
  logic                 g2_use_y_q, g2_zero_q, g2_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) g2_v_q <= 1'b0;
    else g2_v_q <= g1_v_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      g2_prod_q[i] <= PW'(g1_proj_q) * PW'(g1_z_q[i]);
    end
    g2_z_q     <= g1_z_q;
    g2_use_y_q <= g1_use_y_q;
    g2_zero_q  <= g1_zero_q;
  end

  // G3: Gram-Schmidt, reference at 2F fraction bits minus its Z part.
  logic signed [PW-1:0] g3_ref [3];
  logic signed [PW-1:0] g3_xr_q [3];
  logic [SBW-1:0]       g3_sb_q;
  logic                 g3_v_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g3_ref[i] = '0;
    end
    if (g2_use_y_q) g3_ref[1][2*F] = 1'b1;
    else g3_ref[0][2*F] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) g3_v_q <= 1'b0;
    else g3_v_q <= g2_v_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      g3_xr_q[i] <= g3_ref[i] - g2_prod_q[i];
    end
    g3_sb_q <= {g2_zero_q, g2_z_q[0], g2_z_q[1], g2_z_q[2]};
  end

  // Second normalizer: levelled X axis. Z and the absent flag ride along.
  logic signed [ZW-1:0] n2_x [3];
  logic signed [ZW-1:0] n2_z [3];
  logic [SBW-1:0]       n2_sb;
  logic                 n2_v, n2_zero;

  glr_norm #(.IW(PW), .F(F), .SBW(SBW)) u_norm_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (g3_v_q),
    .v_i     (g3_xr_q),
    .sb_i    (g3_sb_q),
    .valid_o (n2_v),
    .zero_o  (n2_zero),
    .u_o     (n2_x),
    .sb_o    (n2_sb)
  );

  assign n2_z[0] = n2_sb[3*ZW-1:2*ZW];
  assign n2_z[1] = n2_sb[2*ZW-1:ZW];
  assign n2_z[2] = n2_sb[ZW-1:0];

  // C1: the six products of the cross product Y = Z x X.
  logic signed [PW-1:0] c1_pa_q [3];
  logic signed [PW-1:0] c1_pb_q [3];
  logic signed [ZW-1:0] c1_x_q [3];
  logic signed [ZW-1:0] c1_z_q [3];
  logic                 c1_absent_q, c1_degen_q, c1_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c1_v_q <= 1'b0;
    else c1_v_q <= n2_v;
  end

  always_ff @(posedge clk_i) begin
    c1_pa_q[0]  <= PW'(n2_z[1]) * PW'(n2_x[2]);
    c1_pb_q[0]  <= PW'(n2_z[2]) * PW'(n2_x[1]);
    c1_pa_q[1]  <= PW'(n2_z[2]) * PW'(n2_x[0]);
    c1_pb_q[1]  <= PW'(n2_z[0]) * PW'(n2_x[2]);
    c1_pa_q[2]  <= PW'(n2_z[0]) * PW'(n2_x[1]);
    c1_pb_q[2]  <= PW'(n2_z[1]) * PW'(n2_x[0]);
    c1_x_q      <= n2_x;
    c1_z_q      <= n2_z;
    c1_absent_q <= n2_sb[SBW-1];
    c1_degen_q  <= n2_zero;
  end

  // C2: differences, kept as magnitude and sign for symmetric rounding.
  logic signed [DW-1:0] c2_diff [3];
  logic [DW-1:0]        c2_mag_q [3];
  logic [2:0]           c2_neg_q;
  logic signed [ZW-1:0] c2_x_q [3];
  logic signed [ZW-1:0] c2_z_q [3];
  logic                 c2_absent_q, c2_degen_q, c2_v_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c2_diff[i] = DW'(c1_pa_q[i]) - DW'(c1_pb_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c2_v_q <= 1'b0;
    else c2_v_q <= c1_v_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      c2_mag_q[i] <= c2_diff[i][DW-1] ? DW'(-c2_diff[i]) : DW'(c2_diff[i]);
      c2_neg_q[i] <= c2_diff[i][DW-1];
    end
    c2_x_q      <= c1_x_q;
    c2_z_q      <= c1_z_q;
    c2_absent_q <= c1_absent_q;
    c2_degen_q  <= c1_degen_q;
  end

  // C3: round half away from zero, clamp to one, and form the result.
  // Either special case forces the whole matrix to zero.
  logic [DW-1:0]                  c3_rnd [3];
  logic signed [ZW-1:0]           c3_y   [3];
  glr_pkg::status_e               c3_status;
  logic signed [glr_pkg::OUT_W-1:0] r_d [3][3];
  logic signed [glr_pkg::OUT_W-1:0] r_q [3][3];
  glr_pkg::status_e               status_q;
  logic                           done_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c3_rnd[i] = (c2_mag_q[i] + (DW'(1) << (F - 1))) >> F;
      if (c3_rnd[i] > (DW'(1) << F)) c3_rnd[i] = DW'(1) << F;
      c3_y[i] = c2_neg_q[i] ? -$signed(ZW'(c3_rnd[i])) : $signed(ZW'(c3_rnd[i]));
    end
    if (c2_absent_q) c3_status = glr_pkg::ST_ABSENT;
    else if (c2_degen_q) c3_status = glr_pkg::ST_DEGEN;
    else c3_status = glr_pkg::ST_OK;
    for (int i = 0; i < 3; i++) begin
      if (c3_status == glr_pkg::ST_OK) begin
        r_d[0][i] = glr_pkg::OUT_W'(c2_x_q[i]);
        r_d[1][i] = glr_pkg::OUT_W'(c3_y[i]);
        r_d[2][i] = glr_pkg::OUT_W'(c2_z_q[i]);
      end else begin
        r_d[0][i] = '0;
        r_d[1][i] = '0;
        r_d[2][i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= c2_v_q;
  end

  always_ff @(posedge clk_i) begin
    r_q      <= r_d;
    status_q <= c3_status;
  end

  assign done_o   = done_q;
  assign status_o = status_q;
  assign r00_o    = r_q[0][0];
  assign r01_o    = r_q[0][1];
  assign r02_o    = r_q[0][2];
  assign r10_o    = r_q[1][0];
  assign r11_o    = r_q[1][1];
  assign r12_o    = r_q[1][2];
  assign r20_o    = r_q[2][0];
  assign r21_o    = r_q[2][1];
  assign r22_o    = r_q[2][2];

endmodule

// ===== rtl/core/glr_checker.sv =====
// Port-level assertions for the gravity levelling rotation core, bound to it.
// Depends on glr_pkg and gravity_level_rotation_core.
`timescale 1ns / 1ps

module glr_checker #(
  parameter int FRACTION_BITS = 14
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic                            done_o,
  input logic [1:0]                      status_o,
  input logic signed [glr_pkg::OUT_W-1:0] r00_o,
  input logic signed [glr_pkg::OUT_W-1:0] r01_o,
  input logic signed [glr_pkg::OUT_W-1:0] r02_o,
  input logic signed [glr_pkg::OUT_W-1:0] r10_o,
  input logic signed [glr_pkg::OUT_W-1:0] r11_o,
  input logic signed [glr_pkg::OUT_W-1:0] r12_o,
  input logic signed [glr_pkg::OUT_W-1:0] r20_o,
  input logic signed [glr_pkg::OUT_W-1:0] r21_o,
  input logic signed [glr_pkg::OUT_W-1:0] r22_o
);

  localparam int LAT = glr_pkg::core_latency(FRACTION_BITS);

  logic accept;
  assign accept = start && !busy;

  // Every accepted item yields its result strobe at the delay given by core_latency.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT done_o)
    else $error("result strobe missing after an accepted item");

  // No result appears without an item accepted at the matching time.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LAT))
    else $error("result strobe without a matching item");

  // A failed normalization gives an all-zero matrix.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != glr_pkg::ST_OK |->
      r00_o == 0 && r01_o == 0 && r02_o == 0 && r10_o == 0 && r11_o == 0 &&
      r12_o == 0 && r20_o == 0 && r21_o == 0 && r22_o == 0)
    else $error("nonzero matrix with a failure status");

  // A good result carries a nonzero gravity row.
  a_ok_row2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == glr_pkg::ST_OK |-> (r20_o | r21_o | r22_o) != 0)
    else $error("zero gravity row with status ok");

endmodule

bind gravity_level_rotation_core glr_checker #(
  .FRACTION_BITS (FRACTION_BITS)
) u_glr_checker (.*);

// ===== verif/gravity_level_rotation_core_test.sv =====
// Self-checking testbench for gravity_level_rotation_core: random and directed gravity
// readings, checked entry by entry against a fixed-point levelling model kept here.
// Depends on glr_pkg and the core RTL.
`timescale 1ns / 1ps

module gravity_level_rotation_core_test;

  localparam int SW   = 16;
  localparam int FB   = 14;
  localparam longint ONE_Q = longint'(1) << FB;
  localparam int LAT  = glr_pkg::core_latency(FB);

  // One expected levelling matrix with its status, entries row-major.
  typedef struct {
    glr_pkg::status_e  status;
    logic signed [15:0] m [9];
  } level_matrix_t;

  // Integer square root by the bit-pair method on 64-bit values.
  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scales a vector to unit length in fixed point. Returns 0 for the zero vector.
  function automatic bit to_unit(input longint v [3], output longint u [3]);
    longint unsigned mag [3];
    longint unsigned peak, sumsq, root, q;
    peak = 0;
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
      if (mag[i] > peak) peak = mag[i];
      u[i] = 0;
    end
    if (peak == 0) return 0;
    // Bring the largest magnitude into [2^30, 2^31) before squaring.
    while (peak >= (longint'(1) << 31)) begin
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      peak = peak >> 1;
    end
    while (peak < (longint'(1) << 30)) begin
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      peak = peak << 1;
    end
    for (int i = 0; i < 3; i++) sumsq = sumsq + mag[i] * mag[i];
    root = int_sqrt(sumsq);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << FB) + (root >> 1)) / root;
      if (q > ONE_Q) q = ONE_Q;
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  // One cross product entry (a*b - c*d), rounded half away from zero and clamped.
  function automatic longint cross_entry(input longint a, b, c, d);
    longint diff, r;
    longint unsigned mag;
    diff = a * b - c * d;
    mag = (diff < 0) ? longint'(-diff) : longint'(diff);
    mag = (mag + (longint'(1) << (FB - 1))) >> FB;
    r = (diff < 0) ? -longint'(mag) : longint'(mag);
    if (r > ONE_Q) r = ONE_Q;
    if (r < -ONE_Q) r = -ONE_Q;
    return r;
  endfunction

  // Full levelling matrix for one reading.
  function automatic level_matrix_t level_matrix(input logic signed [SW-1:0] gx, gy, gz);
    level_matrix_t e;
    longint g [3];
    longint zu [3];
    longint xh [3];
    longint xu [3];
    longint yu [3];
    longint axis [3];
    longint proj, azx;
    e.status = glr_pkg::ST_OK;
    for (int i = 0; i < 9; i++) e.m[i] = '0;
    g[0] = longint'(gx);
    g[1] = longint'(gy);
    g[2] = longint'(gz);
    if (!to_unit(g, zu)) begin
      e.status = glr_pkg::ST_ABSENT;
      return e;
    end
    // Gravity mostly along the x axis makes unit Y the better reference.
    azx = (zu[0] < 0) ? -zu[0] : zu[0];
    axis = '{1, 0, 0};
    if (10 * azx > 9 * ONE_Q) axis = '{0, 1, 0};
    proj = axis[0] * zu[0] + axis[1] * zu[1] + axis[2] * zu[2];
    for (int i = 0; i < 3; i++) xh[i] = axis[i] * ONE_Q * ONE_Q - proj * zu[i];
    if (!to_unit(xh, xu)) begin
      e.status = glr_pkg::ST_DEGEN;
      return e;
    end
    yu[0] = cross_entry(zu[1], xu[2], zu[2], xu[1]);
    yu[1] = cross_entry(zu[2], xu[0], zu[0], xu[2]);
    yu[2] = cross_entry(zu[0], xu[1], zu[1], xu[0]);
    for (int i = 0; i < 3; i++) begin
      e.m[i]     = xu[i][15:0];
      e.m[3 + i] = yu[i][15:0];
      e.m[6 + i] = zu[i][15:0];
    end
    return e;
  endfunction

  // Holds the matrices still owed by the core, oldest first.
  class level_scoreboard;
    level_matrix_t owed [$];
    int errors;
    int n_ok, n_absent, n_degen;

    function new();
      errors = 0;
      n_ok = 0;
      n_absent = 0;
      n_degen = 0;
    endfunction

    task report(input string what);
      errors++;
      $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    function void note_reading(input logic signed [SW-1:0] gx, gy, gz);
      owed.push_back(level_matrix(gx, gy, gz));
    endfunction

    task check_matrix(input logic [1:0] st, input logic signed [15:0] got [9]);
      level_matrix_t e;
      if (owed.size() == 0) begin
        report("result strobe with no reading outstanding");
      end else begin
        e = owed.pop_front();
        case (e.status)
          glr_pkg::ST_OK:     n_ok++;
          glr_pkg::ST_ABSENT: n_absent++;
          default:            n_degen++;
        endcase
        if (st !== e.status)
          report($sformatf("status got %0d want %0d", st, e.status));
        for (int i = 0; i < 9; i++)
          if (got[i] !== e.m[i])
            report($sformatf("r%0d%0d got %0d want %0d", i / 3, i % 3, got[i], e.m[i]));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic signed [SW-1:0] grav_x_i = '0;
  logic signed [SW-1:0] grav_y_i = '0;
  logic signed [SW-1:0] grav_z_i = '0;
  logic busy, done_o;
  logic [1:0] status_o;
  logic signed [15:0] r00_o, r01_o, r02_o, r10_o, r11_o, r12_o, r20_o, r21_o, r22_o;

  level_scoreboard sb = new();
  int n_sent = 0;

  gravity_level_rotation_core #(.SAMPLE_WIDTH(SW), .FRACTION_BITS(FB)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .grav_x_i(grav_x_i), .grav_y_i(grav_y_i), .grav_z_i(grav_z_i),
    .done_o(done_o), .status_o(status_o),
    .r00_o(r00_o), .r01_o(r01_o), .r02_o(r02_o),
    .r10_o(r10_o), .r11_o(r11_o), .r12_o(r12_o),
    .r20_o(r20_o), .r21_o(r21_o), .r22_o(r22_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Results are sampled at the edge that ends their strobe cycle.
  always @(posedge clk_i) begin
    logic signed [15:0] got [9];
    if (rst_ni && done_o === 1'b1) begin
      got = '{r00_o, r01_o, r02_o, r10_o, r11_o, r12_o, r20_o, r21_o, r22_o};
      sb.check_matrix(status_o, got);
    end
  end

  // Presents one reading and holds it until the core takes it.
  task send_reading(input logic signed [SW-1:0] gx, gy, gz);
    start <= 1'b1;
    grav_x_i <= gx;
    grav_y_i <= gy;
    grav_z_i <= gz;
    do @(posedge clk_i); while (busy === 1'b1);
    sb.note_reading(gx, gy, gz);
    n_sent++;
  endtask

  task idle_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Random reading drawn from one of several shapes so that both reference
  // axes, tiny vectors and the full range all show up often.
  task send_random;
    logic signed [SW-1:0] gx, gy, gz;
    int shape;
    shape = $urandom_range(0, 9);
    gx = SW'($urandom);
    gy = SW'($urandom);
    gz = SW'($urandom);
    case (shape)
      0, 1, 2: ;
      3: begin // board lying flat, gravity mostly along z
        gx = SW'(int'($urandom_range(0, 2000)) - 1000);
        gy = SW'(int'($urandom_range(0, 2000)) - 1000);
      end
      4, 5: begin // gravity mostly along x, which selects unit Y
        gy = SW'(int'($urandom_range(0, 8000)) - 4000);
        gz = SW'(int'($urandom_range(0, 8000)) - 4000);
        gx = ($urandom_range(0, 1)) ? SW'(28672 + int'($urandom_range(0, 4095)))
                                    : SW'(-28672 - int'($urandom_range(0, 4096)));
      end
      6: begin // around the reference switch point, |x| near 0.9 of the length
        gx = ($urandom_range(0, 1)) ? 16'sd9000 : -16'sd9000;
        gy = SW'(int'($urandom_range(0, 9000)) - 4500);
        gz = SW'(int'($urandom_range(0, 9000)) - 4500);
      end
      7: begin // very short vectors
        gx = SW'(int'($urandom_range(0, 6)) - 3);
        gy = SW'(int'($urandom_range(0, 6)) - 3);
        gz = SW'(int'($urandom_range(0, 6)) - 3);
      end
      8: begin // one or two axes exactly zero
        if ($urandom_range(0, 1)) gx = '0;
        if ($urandom_range(0, 1)) gy = '0;
        else gz = '0;
      end
      default: begin // extremes of the sample range
        gx = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        if ($urandom_range(0, 1)) gy = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end
    endcase
    send_reading(gx, gy, gz);
  endtask

  initial begin
    int burst;
    bit drained;
    drained = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed readings: zero vector, axis extremes, both reference choices,
    // the switch threshold and the smallest nonzero vectors.
    send_reading(0, 0, 0);
    send_reading(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_reading(16'sh8000, 16'sh8000, 16'sh8000);
    send_reading(16'sh8000, 0, 0);
    send_reading(16'sh7fff, 0, 0);
    send_reading(0, 16'sh8000, 0);
    send_reading(0, 16'sh7fff, 0);
    send_reading(0, 0, 16'sh8000);
    send_reading(0, 0, 16'sh7fff);
    send_reading(1, 0, 0);
    send_reading(0, -1, 0);
    send_reading(0, 0, 1);
    send_reading(-1, -1, -1);
    send_reading(9, 4, 0);
    send_reading(-9, 0, 4);
    send_reading(9000, 4359, 0);
    send_reading(9000, 4360, 0);
    send_reading(16'sh8000, 16'sh7fff, 16'sh8000);
    send_reading(16'sh7fff, 16'sh8000, 1);
    send_reading(100, -200, 16384);
    send_reading(0, 0, 0);
    idle_cycles(3);

    while (n_sent < 1650) begin
      burst = $urandom_range(1, 40);
      repeat (burst) send_random();
      // Back-to-back stretches are common; otherwise a gap of random length.
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
      // Once, midway, let the pipeline drain completely.
      if (!drained && n_sent > 800) begin
        drained = 1'b1;
        start <= 1'b0;
        while (sb.owed.size() != 0) @(posedge clk_i);
      end
    end
    start <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (LAT + 10) @(posedge clk_i);

    $display("Sent %0d readings: %0d levelled, %0d zero-vector, %0d degenerate.",
             n_sent, sb.n_ok, sb.n_absent, sb.n_degen);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("gravity_level_rotation_core verification clean");
    end else begin
      $display("gravity_level_rotation_core verification failed");
    end
    $finish;
  end

  // Hard stop in case results never arrive.
  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding.", sb.owed.size());
    $display("gravity_level_rotation_core verification failed");
    $finish;
  end

endmodule
